### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check b in the same cycle whenever a holds.
`define ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Check b in the cycle after a holds.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_NOW(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

### src/srted_pkg.sv
// ----------------------------------------------------------------------------
// srted_pkg
// Shared codes and types of the serial receive escape / telnet decoder.
// ----------------------------------------------------------------------------
package srted_pkg;

    localparam logic [7:0] IAC_BYTE   = 8'hff;
    localparam logic [7:0] CMD_GA     = 8'd249;
    localparam logic [7:0] CMD_SB     = 8'd250;
    localparam logic [7:0] CMD_WILL   = 8'd251;
    localparam logic [7:0] CMD_WONT   = 8'd252;
    localparam logic [7:0] CMD_DO     = 8'd253;
    localparam logic [7:0] CMD_DONT   = 8'd254;
    localparam logic [7:0] OPT_BINARY = 8'd0;
    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_SGA    = 8'd3;

    localparam int unsigned MAX_RESULTS = 3;

    // Register indexes of the configuration port
    localparam logic CFG_TELNET_MODE      = 1'b0;
    localparam logic CFG_TRANSPARENT_MODE = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_BREAK  = 2'd1,
        KIND_REPLY  = 2'd2,
        KIND_STATUS = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
    } result_t;

    // All results caused by one received byte; items[0] goes out first
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] items;
        logic [1:0]                count;
        logic                      cts;
        logic                      dsr;
    } burst_t;

    typedef struct packed {
        logic telnet_mode;
        logic transparent_mode;
    } cfg_t;

endpackage

### src/serial_rx_escape_and_telnet_decoder.sv
// ----------------------------------------------------------------------------
// serial_rx_escape_and_telnet_decoder
// Receive-side decoder for an emulated serial port fed by a network peer.
// ----------------------------------------------------------------------------
// Each byte from the peer is taken into a one-byte input register, decoded
// combinationally into a burst of zero to three results, and the burst is
// loaded into the output register, from which one result beat leaves per
// cycle unless stalled; last marks the final beat of a burst. A byte thus
// holds the output for one beat per result (one for data, up to two for a
// status escape, three for a telnet reply); bytes that cause no result pass
// at one per cycle while the output is empty. The input register takes a
// new byte while a burst still waits on the output, so the two sides are
// decoupled by one stage. Decoder state advances when a byte moves from the
// input register into the output register. Configuration writes (telnet_mode
// index 0, transparent_mode index 1) are always ready and are registered.
module serial_rx_escape_and_telnet_decoder (
    input  logic       clk,
    input  logic       rst_n,
    // input byte channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] value,
    output logic       last,
    output logic       cts,
    output logic       dsr,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic       cfg_data
);

`include "assert_macros.svh"

    srted_pkg::cfg_t   cfg_reg;
    srted_pkg::burst_t burst;

    logic       hold_valid_reg;
    logic [7:0] hold_byte_reg;

    logic                                          out_valid_reg;
    srted_pkg::result_t [srted_pkg::MAX_RESULTS-1:0] items_reg, items_next;
    logic [1:0]                                    count_reg;
    logic                                          cts_reg;
    logic                                          dsr_reg;

    logic in_beat;
    logic out_beat;
    logic move;

    assign cfg_ready = 1'b1;

    // Take a config beat whenever it shows up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                srted_pkg::CFG_TELNET_MODE:      cfg_reg.telnet_mode      <= cfg_data;
                srted_pkg::CFG_TRANSPARENT_MODE: cfg_reg.transparent_mode <= cfg_data;
                default:                         cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Advance the held byte once the output is empty or on its last beat
    assign out_beat = out_valid_reg && !out_stall;
    assign last     = (count_reg == 2'd1);
    assign move     = hold_valid_reg && (!out_valid_reg || (out_beat && last));
    assign in_stall = hold_valid_reg && !move;
    assign in_beat  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_beat)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (move)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
            hold_byte_reg <= rx_byte;
    end

    srted_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (move),
        .byte_in (hold_byte_reg),
        .cfg     (cfg_reg),
        .burst   (burst)
    );

    // Shift the burst down one result per beat
    always_comb
    begin
        items_next = items_reg;
        for (int i = 0; i < srted_pkg::MAX_RESULTS - 1; i++)
            items_next[i] = items_reg[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= 2'd0;
        end
        else if (move)
        begin
            out_valid_reg <= (burst.count != 2'd0);
            count_reg     <= burst.count;
        end
        else if (out_beat)
        begin
            out_valid_reg <= !last;
            count_reg     <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            items_reg <= burst.items;
            cts_reg   <= burst.cts;
            dsr_reg   <= burst.dsr;
        end
        else if (out_beat)
        begin
            items_reg <= items_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = items_reg[0].kind;
    assign value     = items_reg[0].value;
    assign cts       = cts_reg;
    assign dsr       = dsr_reg;

    // A shown burst always has a result left
    `ASSERT_NOW(a_count_nonzero, clk, rst_n, out_valid_reg, count_reg != 2'd0)
    // A beat that is not the last leaves the rest of the burst on the output
    `ASSERT_NEXT(a_burst_continues, clk, rst_n, out_beat && !last, out_valid_reg)
    `ASSERT_NEXT(a_count_steps, clk, rst_n, out_beat && !last && !move,
                 count_reg == $past(count_reg) - 2'd1)
    // A byte blocked behind the output is still held next cycle
    `ASSERT_NEXT(a_hold_kept, clk, rst_n, hold_valid_reg && !move, hold_valid_reg)

endmodule

### src/srted_decode.sv
// ----------------------------------------------------------------------------
// srted_decode
// Decoder state and the per-byte decode into a burst of up to three results.
// ----------------------------------------------------------------------------
module srted_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            byte_in,
    input  srted_pkg::cfg_t       cfg,
    output srted_pkg::burst_t     burst
);

    // Option flags other than binary_peer never affect any result,
    // so only the flags that steer decoding are kept.
    logic       escape_pending_reg, escape_pending_next;
    logic       in_command_reg, in_command_next;
    logic       have_command_reg, have_command_next;
    logic [7:0] command_code_reg, command_code_next;
    logic       binary_peer_reg, binary_peer_next;
    logic       cts_line_reg, cts_line_next;
    logic       dsr_line_reg, dsr_line_next;

    function automatic srted_pkg::result_t [srted_pkg::MAX_RESULTS-1:0] reply3(
        input logic [7:0] cmd,
        input logic [7:0] opt
    );
        srted_pkg::result_t [srted_pkg::MAX_RESULTS-1:0] r;
        r[0].kind  = srted_pkg::KIND_REPLY;
        r[0].value = srted_pkg::IAC_BYTE;
        r[1].kind  = srted_pkg::KIND_REPLY;
        r[1].value = cmd;
        r[2].kind  = srted_pkg::KIND_REPLY;
        r[2].value = opt;
        return r;
    endfunction

    always_comb
    begin
        logic known;
        known = (byte_in == srted_pkg::OPT_BINARY) || (byte_in == srted_pkg::OPT_ECHO)
             || (byte_in == srted_pkg::OPT_SGA);

        escape_pending_next = escape_pending_reg;
        in_command_next     = in_command_reg;
        have_command_next   = have_command_reg;
        command_code_next   = command_code_reg;
        binary_peer_next    = binary_peer_reg;
        cts_line_next       = cts_line_reg;
        dsr_line_next       = dsr_line_reg;

        burst.count = 2'd0;
        for (int i = 0; i < srted_pkg::MAX_RESULTS; i++)
        begin
            burst.items[i].kind  = srted_pkg::KIND_DATA;
            burst.items[i].value = 8'd0;
        end

        if (cfg.telnet_mode)
        begin
            if (!in_command_reg)
            begin
                if (byte_in == srted_pkg::IAC_BYTE)
                begin
                    in_command_next = 1'b1;
                end
                else
                begin
                    burst.items[0].value = byte_in;
                    burst.count          = 2'd1;
                end
            end
            else if (!have_command_reg)
            begin
                if (byte_in == srted_pkg::CMD_GA)
                begin
                    in_command_next = 1'b0;
                end
                else
                begin
                    command_code_next = byte_in;
                    have_command_next = 1'b1;
                    // escaped 0xff counts as data only in peer binary mode
                    if (binary_peer_reg && byte_in == srted_pkg::IAC_BYTE)
                    begin
                        in_command_next      = 1'b0;
                        have_command_next    = 1'b0;
                        burst.items[0].value = srted_pkg::IAC_BYTE;
                        burst.count          = 2'd1;
                    end
                end
            end
            else
            begin
                in_command_next   = 1'b0;
                have_command_next = 1'b0;
                if (!known && command_code_reg > srted_pkg::CMD_SB)
                begin
                    burst.items = reply3(srted_pkg::CMD_WONT, byte_in);
                    burst.count = 2'd3;
                end
                if (command_code_reg == srted_pkg::CMD_WILL
                    || command_code_reg == srted_pkg::CMD_WONT)
                begin
                    if (byte_in == srted_pkg::OPT_BINARY)
                        binary_peer_next = (command_code_reg == srted_pkg::CMD_WILL);
                end
                else if (command_code_reg == srted_pkg::CMD_DO
                         || command_code_reg == srted_pkg::CMD_DONT)
                begin
                    if (byte_in == srted_pkg::OPT_BINARY)
                    begin
                        burst.items = reply3((command_code_reg == srted_pkg::CMD_DO)
                                             ? srted_pkg::CMD_WILL : srted_pkg::CMD_WONT,
                                             srted_pkg::OPT_BINARY);
                        burst.count = 2'd3;
                    end
                    else if (byte_in == srted_pkg::OPT_ECHO)
                    begin
                        burst.items = reply3(srted_pkg::CMD_WONT, srted_pkg::OPT_ECHO);
                        burst.count = 2'd3;
                    end
                    else if (byte_in == srted_pkg::OPT_SGA)
                    begin
                        burst.items = reply3(srted_pkg::CMD_WILL, srted_pkg::OPT_SGA);
                        burst.count = 2'd3;
                    end
                end
            end
        end
        else if (escape_pending_reg)
        begin
            escape_pending_next = 1'b0;
            if (byte_in == srted_pkg::IAC_BYTE)
            begin
                burst.items[0].value = srted_pkg::IAC_BYTE;
                burst.count          = 2'd1;
            end
            else
            begin
                cts_line_next        = byte_in[0];
                dsr_line_next        = byte_in[1];
                burst.items[0].kind  = srted_pkg::KIND_STATUS;
                burst.items[1].kind  = srted_pkg::KIND_BREAK;
                burst.count          = byte_in[2] ? 2'd2 : 2'd1;
            end
        end
        else if (byte_in == srted_pkg::IAC_BYTE && !cfg.transparent_mode)
        begin
            escape_pending_next = 1'b1;
        end
        else
        begin
            burst.items[0].value = byte_in;
            burst.count          = 2'd1;
        end

        burst.cts = cts_line_next;
        burst.dsr = dsr_line_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
            in_command_reg     <= 1'b0;
            have_command_reg   <= 1'b0;
            command_code_reg   <= 8'd0;
            binary_peer_reg    <= 1'b0;
            cts_line_reg       <= 1'b0;
            dsr_line_reg       <= 1'b0;
        end
        else if (step)
        begin
            escape_pending_reg <= escape_pending_next;
            in_command_reg     <= in_command_next;
            have_command_reg   <= have_command_next;
            command_code_reg   <= command_code_next;
            binary_peer_reg    <= binary_peer_next;
            cts_line_reg       <= cts_line_next;
            dsr_line_reg       <= dsr_line_next;
        end
    end

endmodule

### verif/serial_rx_escape_and_telnet_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_rx_escape_and_telnet_decoder_test
// Self-checking bench for the receive decoder. Bytes go in over the input
// channel. A local model of the escape and telnet parsers predicts every
// result beat, and each beat that leaves is compared against the oldest
// prediction. The run walks a short directed table, then random phases
// under every mode setting, with random gaps, a long receiver hold-off and a
// sender pause until the outputs have drained.
// ----------------------------------------------------------------------------
module serial_rx_escape_and_telnet_decoder_test;

    // Cycles to let a byte with no result clear both stages before a mode write
    localparam int LATENCY_CYCLES = 8;
    // Cycles the receiver holds off during the pressure phase
    localparam int HOLD_CYCLES    = 150;
    // Cycles without any accepted beat before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 47;
    localparam int NUM_PHASES     = 6;
    localparam int NUM_ROWS       = 27;
    localparam int REPORT_LIMIT   = 10;

    // One result beat as seen on the output channel
    typedef struct packed {
        srted_pkg::kind_t kind;
        logic [7:0]       value;
        logic             last;
        logic             cts;
        logic             dsr;
    } beat_t;

    // One directed stimulus row: mode, byte, and a typed-in beat where it is
    // obvious (a single result with last set); other rows use the model.
    typedef struct packed {
        logic             telnet;
        logic             transp;
        logic [7:0]       rx;
        logic             typed;
        srted_pkg::kind_t kind;
        logic [7:0]       val;
        logic             cts;
        logic             dsr;
    } row_t;

    localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // plain data right after reset, lines still low
        '{1'b0, 1'b0, 8'h00, 1'b1, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        // escape with CTS and DSR set, no break
        '{1'b0, 1'b0, srted_pkg::IAC_BYTE, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        '{1'b0, 1'b0, 8'h03, 1'b1, srted_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b1},
        // doubled 0xff is literal data
        '{1'b0, 1'b0, srted_pkg::IAC_BYTE, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        '{1'b0, 1'b0, srted_pkg::IAC_BYTE, 1'b1, srted_pkg::KIND_DATA,
          srted_pkg::IAC_BYTE, 1'b1, 1'b1},
        // leave an escape pending, then go transparent: it still resolves,
        // status first and then the break
        '{1'b0, 1'b0, srted_pkg::IAC_BYTE, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        '{1'b0, 1'b1, 8'h04, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        // transparent: 0xff is plain data
        '{1'b0, 1'b1, srted_pkg::IAC_BYTE, 1'b1, srted_pkg::KIND_DATA,
          srted_pkg::IAC_BYTE, 1'b0, 1'b0},
        // telnet, binary off: IAC IAC is a command, option 5 is refused
        '{1'b1, 1'b0, srted_pkg::IAC_BYTE, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        '{1'b1, 1'b0, srted_pkg::IAC_BYTE, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        '{1'b1, 1'b0, 8'h05, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        // go-ahead is dropped
        '{1'b1, 1'b0, srted_pkg::IAC_BYTE, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        '{1'b1, 1'b0, srted_pkg::CMD_GA, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        // DO echo is always answered WONT echo
        '{1'b1, 1'b0, srted_pkg::IAC_BYTE, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        '{1'b1, 1'b0, srted_pkg::CMD_DO, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        '{1'b1, 1'b0, srted_pkg::OPT_ECHO, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        // peer declares binary
        '{1'b1, 1'b0, srted_pkg::IAC_BYTE, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        '{1'b1, 1'b0, srted_pkg::CMD_WILL, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        '{1'b1, 1'b0, srted_pkg::OPT_BINARY, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        // now IAC IAC is data 0xff
        '{1'b1, 1'b0, srted_pkg::IAC_BYTE, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        '{1'b1, 1'b0, srted_pkg::IAC_BYTE, 1'b1, srted_pkg::KIND_DATA,
          srted_pkg::IAC_BYTE, 1'b0, 1'b0},
        // DONT suppress-go-ahead is answered WILL suppress-go-ahead
        '{1'b1, 1'b0, srted_pkg::IAC_BYTE, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        '{1'b1, 1'b0, srted_pkg::CMD_DONT, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        '{1'b1, 1'b0, srted_pkg::OPT_SGA, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        // subnegotiation range: option byte swallowed, no reply
        '{1'b1, 1'b0, srted_pkg::IAC_BYTE, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        '{1'b1, 1'b0, srted_pkg::CMD_SB, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0},
        '{1'b1, 1'b0, 8'h07, 1'b0, srted_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
    logic       cts;
    logic       dsr;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic       cfg_data;

    // Model copy of the mode registers and the decoder state
    logic       mode_telnet;
    logic       mode_transparent;
    logic       esc_pend;
    logic       in_cmd;
    logic       have_cmd;
    logic [7:0] cmd_code;
    logic       bin_peer;
    logic       bin_local;
    logic       echo_peer;
    logic       echo_local;
    logic       sga_peer;
    logic       sga_local;
    logic       cts_line;
    logic       dsr_line;

    srted_pkg::result_t decoded_burst [$];
    beat_t              expected_beats [$];

    int         mismatch_count;
    bit         tx_gaps_on;
    bit         rx_gaps_on;
    bit         hold_request;

    serial_rx_escape_and_telnet_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .value     (value),
        .last      (last),
        .cts       (cts),
        .dsr       (dsr),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // Queue the three-byte telnet answer IAC cmd opt
    function automatic void queue_reply(input logic [7:0] cmd, input logic [7:0] opt);
        decoded_burst.push_back('{kind: srted_pkg::KIND_REPLY, value: srted_pkg::IAC_BYTE});
        decoded_burst.push_back('{kind: srted_pkg::KIND_REPLY, value: cmd});
        decoded_burst.push_back('{kind: srted_pkg::KIND_REPLY, value: opt});
    endfunction

    // Advance the model by one byte; leave its results in decoded_burst
    function automatic void decode_rx_byte(input logic [7:0] b);
        logic known;
        decoded_burst.delete();
        if (mode_telnet)
        begin
            if (!in_cmd)
            begin
                if (b == srted_pkg::IAC_BYTE)
                    in_cmd = 1'b1;
                else
                    decoded_burst.push_back('{kind: srted_pkg::KIND_DATA, value: b});
            end
            else if (!have_cmd)
            begin
                if (b == srted_pkg::CMD_GA)
                    in_cmd = 1'b0;
                else if (bin_peer && b == srted_pkg::IAC_BYTE)
                begin
                    // escaped 0xff under binary: back to plain data
                    cmd_code = b;
                    in_cmd   = 1'b0;
                    have_cmd = 1'b0;
                    decoded_burst.push_back('{kind: srted_pkg::KIND_DATA,
                                              value: srted_pkg::IAC_BYTE});
                end
                else
                begin
                    cmd_code = b;
                    have_cmd = 1'b1;
                end
            end
            else
            begin
                known = (b == srted_pkg::OPT_BINARY) || (b == srted_pkg::OPT_ECHO)
                     || (b == srted_pkg::OPT_SGA);
                // refuse unknown options of WILL/WONT/DO/DONT and command 255
                if (!known && cmd_code > srted_pkg::CMD_SB)
                    queue_reply(srted_pkg::CMD_WONT, b);
                if (cmd_code == srted_pkg::CMD_WILL || cmd_code == srted_pkg::CMD_WONT)
                begin
                    if (b == srted_pkg::OPT_BINARY)
                        bin_peer = (cmd_code == srted_pkg::CMD_WILL);
                    if (b == srted_pkg::OPT_ECHO)
                        echo_peer = (cmd_code == srted_pkg::CMD_WILL);
                    if (b == srted_pkg::OPT_SGA)
                        sga_peer = (cmd_code == srted_pkg::CMD_WILL);
                end
                else if (cmd_code == srted_pkg::CMD_DO || cmd_code == srted_pkg::CMD_DONT)
                begin
                    if (b == srted_pkg::OPT_BINARY)
                    begin
                        bin_local = (cmd_code == srted_pkg::CMD_DO);
                        queue_reply(bin_local ? srted_pkg::CMD_WILL : srted_pkg::CMD_WONT,
                                    srted_pkg::OPT_BINARY);
                    end
                    else if (b == srted_pkg::OPT_ECHO)
                    begin
                        echo_local = 1'b0;
                        queue_reply(srted_pkg::CMD_WONT, srted_pkg::OPT_ECHO);
                    end
                    else if (b == srted_pkg::OPT_SGA)
                    begin
                        sga_local = 1'b1;
                        queue_reply(srted_pkg::CMD_WILL, srted_pkg::OPT_SGA);
                    end
                end
                in_cmd   = 1'b0;
                have_cmd = 1'b0;
            end
        end
        else if (esc_pend)
        begin
            // resolve the escape even if transparent mode came on meanwhile
            esc_pend = 1'b0;
            if (b == srted_pkg::IAC_BYTE)
                decoded_burst.push_back('{kind: srted_pkg::KIND_DATA,
                                          value: srted_pkg::IAC_BYTE});
            else
            begin
                cts_line = b[0];
                dsr_line = b[1];
                decoded_burst.push_back('{kind: srted_pkg::KIND_STATUS, value: 8'h00});
                if (b[2])
                    decoded_burst.push_back('{kind: srted_pkg::KIND_BREAK, value: 8'h00});
            end
        end
        else if (b == srted_pkg::IAC_BYTE && !mode_transparent)
            esc_pend = 1'b1;
        else
            decoded_burst.push_back('{kind: srted_pkg::KIND_DATA, value: b});
    endfunction

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------

    // Offer one byte, with random gaps ahead of it, and hold it until taken.
    // On the beat, advance the model and queue the expected results.
    task automatic send_byte(input logic [7:0] b, input logic typed, input beat_t typed_beat);
        while (tx_gaps_on && $urandom_range(0, 99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // do not drop valid here: the next call drives it once in this step
        decode_rx_byte(b);
        if (typed)
            expected_beats.push_back(typed_beat);
        else
            foreach (decoded_burst[i])
                expected_beats.push_back('{kind: decoded_burst[i].kind,
                                           value: decoded_burst[i].value,
                                           last: (i == decoded_burst.size() - 1),
                                           cts: cts_line,
                                           dsr: dsr_line});
    endtask

    // Drop valid, wait for every expected beat, then let the pipe empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (LATENCY_CYCLES) @(posedge clk);
    endtask

    // Write both mode registers back to back; call only while idle
    task automatic set_mode(input logic telnet, input logic transp);
        cfg_valid <= 1'b1;
        cfg_index <= srted_pkg::CFG_TELNET_MODE;
        cfg_data  <= telnet;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mode_telnet = telnet;
        cfg_index <= srted_pkg::CFG_TRANSPARENT_MODE;
        cfg_data  <= transp;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mode_transparent = transp;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_option();
        case ($urandom_range(0, 3))
            0:       return srted_pkg::OPT_BINARY;
            1:       return srted_pkg::OPT_ECHO;
            2:       return srted_pkg::OPT_SGA;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Send one random unit: well-formed commands and escapes with random
    // content, plain data, and some raw noise bytes.
    task automatic send_random_unit(output int sent);
        int         pick;
        logic [7:0] cmd;
        pick = $urandom_range(0, 99);
        sent = 0;
        if (pick >= 85)
        begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            sent = 1;
        end
        else if (mode_telnet)
        begin
            if (pick < 35)
            begin
                send_byte(8'($urandom_range(0, 254)), 1'b0, '0);
                sent = 1;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 7:    cmd = srted_pkg::CMD_WILL;
                    1, 8:    cmd = srted_pkg::CMD_WONT;
                    2, 9:    cmd = srted_pkg::CMD_DO;
                    3:       cmd = srted_pkg::CMD_DONT;
                    4:       cmd = srted_pkg::CMD_GA;
                    5:       cmd = srted_pkg::IAC_BYTE;
                    6:       cmd = $urandom_range(0, 1) ? srted_pkg::CMD_SB
                                                        : 8'($urandom_range(240, 248));
                    default: cmd = srted_pkg::CMD_DONT;
                endcase
                send_byte(srted_pkg::IAC_BYTE, 1'b0, '0);
                send_byte(cmd, 1'b0, '0);
                sent = 2;
                // IAC IAC and go-ahead end here; the rest take an option
                if (cmd != srted_pkg::CMD_GA && cmd != srted_pkg::IAC_BYTE)
                begin
                    send_byte(random_option(), 1'b0, '0);
                    sent = 3;
                end
            end
        end
        else
        begin
            if (pick < 45)
            begin
                send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                sent = 1;
            end
            else
            begin
                send_byte(srted_pkg::IAC_BYTE, 1'b0, '0);
                if (pick < 70)
                    send_byte(srted_pkg::IAC_BYTE, 1'b0, '0);
                else
                    send_byte(8'($urandom_range(0, 254)), 1'b0, '0);
                sent = 2;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int   sent;
        int   n;
        bit   telnet_seq [NUM_PHASES];
        bit   transp_seq [NUM_PHASES];
        row_t row;

        telnet_seq = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
        transp_seq = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

        // drive every input to a known value from time zero
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        rx_byte   <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= srted_pkg::CFG_TELNET_MODE;
        cfg_data  <= 1'b0;

        mode_telnet      = 1'b0;
        mode_transparent = 1'b0;
        esc_pend         = 1'b0;
        in_cmd           = 1'b0;
        have_cmd         = 1'b0;
        cmd_code         = 8'h00;
        bin_peer         = 1'b0;
        bin_local        = 1'b0;
        echo_peer        = 1'b0;
        echo_local       = 1'b0;
        sga_peer         = 1'b0;
        sga_local        = 1'b0;
        cts_line         = 1'b0;
        dsr_line         = 1'b0;
        mismatch_count   = 0;
        tx_gaps_on       = 1'b1;
        rx_gaps_on       = 1'b1;
        hold_request     = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_mode(1'b0, 1'b0);

        // Directed table: switch modes only once the block has gone quiet
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row = DIRECTED_ROWS[r];
            if (row.telnet !== mode_telnet || row.transp !== mode_transparent)
            begin
                wait_idle();
                set_mode(row.telnet, row.transp);
            end
            send_byte(row.rx, row.typed,
                      '{kind: row.kind, value: row.val, last: 1'b1,
                        cts: row.cts, dsr: row.dsr});
        end

        // Random phases over every mode setting; parser state carries over
        // from one phase to the next, so mode switches land mid-sequence.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            set_mode(telnet_seq[p], transp_seq[p]);
            // phase 2 runs with no gaps on either side
            tx_gaps_on = (p != 2);
            rx_gaps_on = (p != 2);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                send_random_unit(n);
                sent += n;
                // long receiver hold-off while bytes keep coming
                if (p == 1 && sent >= 10 && sent < 10 + n)
                    hold_request = 1'b1;
                // sender pause until every result has left
                if (p == 4 && sent >= 25 && sent < 25 + n)
                    wait_idle();
            end
        end

        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        wait_idle();

        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, plus one long hold-off counted here
    // ------------------------------------------------------------------
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            else
                out_stall <= rx_gaps_on && ($urandom_range(0, 99) < 31);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        beat_t got;
        beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {srted_pkg::kind_t'(kind), value, last, cts, dsr};
            if (expected_beats.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected beat: kind=%0d value=%02h last=%0b cts=%0b dsr=%0b",
                             got.kind, got.value, got.last, got.cts, got.dsr);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("beat mismatch: got kind=%0d value=%02h last=%0b cts=%0b dsr=%0b",
                                 got.kind, got.value, got.last, got.cts, got.dsr);
                        $display("               want kind=%0d value=%02h last=%0b cts=%0b dsr=%0b",
                                 want.kind, want.value, want.last, want.cts, want.dsr);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run after too many cycles with no beat on any channel
    // ------------------------------------------------------------------
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule
